// ===== rtl/srep_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Stream pattern replace package
// Shared types, register indexes, reset values and a byte helper.
// ----------------------------------------------------------------------------
package srep_pkg;

	localparam int MAX_PATTERN_DEF     = 8;
	localparam int MAX_REPLACEMENT_DEF = 8;
	localparam int QUEUE_DEPTH_DEF     = 2;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 64;
	localparam int WORD_BYTES  = CFG_DATA_W / 8;
	localparam int LENGTH_W    = 4;
	localparam int COUNT_W     = 16;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_PATTERN_BYTES,
		REG_PATTERN_LENGTH,
		REG_REPLACEMENT_BYTES,
		REG_REPLACEMENT_LENGTH,
		REG_REPLACE_EVERY,
		REG_OUTPUT_LIMIT
	} cfg_reg_t;

	localparam logic [CFG_DATA_W-1:0] PATTERN_BYTES_RST      = '0;
	localparam logic [LENGTH_W-1:0]   PATTERN_LENGTH_RST     = 4'd1;
	localparam logic [CFG_DATA_W-1:0] REPLACEMENT_BYTES_RST  = '0;
	localparam logic [LENGTH_W-1:0]   REPLACEMENT_LENGTH_RST = 4'd0;
	localparam logic                  REPLACE_EVERY_RST      = 1'b1;
	localparam logic [COUNT_W-1:0]    OUTPUT_LIMIT_RST       = 16'hFFFF;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_text;
	} in_item_t;

	typedef struct packed {
		logic [7:0]         out_byte;
		logic               byte_present;
		logic               end_of_result;
		logic [COUNT_W-1:0] result_length;
	} out_item_t;

	// Byte k of a configuration word; bytes past the word read as zero.
	function automatic logic [7:0] byte_of(input logic [CFG_DATA_W-1:0] word,
			input int unsigned k);
		logic [7:0] b;
		b = 8'd0;
		if (k < WORD_BYTES) begin
			b = word[8*k +: 8];
		end
		return b;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/srep_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Command queue
// Small register FIFO between the classifying front and the emitting back.
// ----------------------------------------------------------------------------
module srep_queue import srep_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      head_data,
	output logic                  full,
	output logic                  empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [NW-1:0]    count_q;

	function automatic logic [AW-1:0] next_ptr(input logic [AW-1:0] p);
		logic [AW-1:0] n;
		n = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
		return n;
	endfunction

	assign full      = (count_q == NW'(DEPTH));
	assign empty     = (count_q == '0);
	assign head_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			case ({push, pop})
				2'b10: count_q <= count_q + NW'(1);
				2'b01: count_q <= count_q - NW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== rtl/srep_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Match front
// Holds the pending window, compares it with the pattern and queues an
// emit command for each text byte that releases bytes or ends the text.
// ----------------------------------------------------------------------------
module srep_front import srep_pkg::*; #(
	parameter int MAX_PATTERN     = MAX_PATTERN_DEF,
	parameter int MAX_REPLACEMENT = MAX_REPLACEMENT_DEF,
	localparam int CMAX = (MAX_PATTERN > MAX_REPLACEMENT) ? MAX_PATTERN : MAX_REPLACEMENT,
	localparam int CW   = $clog2(CMAX + 1)
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                   text_valid,
	output logic                        text_stall,
	input  wire in_item_t               text,
	output logic                        cmd_push,
	output logic [CMAX-1:0][7:0]        cmd_bytes,
	output logic [CW-1:0]               cmd_count,
	output logic                        cmd_last,
	input  wire logic                   queue_full
);

	localparam int PW  = $clog2(MAX_PATTERN + 1);
	localparam int RW  = $clog2(MAX_REPLACEMENT + 1);
	localparam int PLW = (PW > LENGTH_W) ? PW : LENGTH_W;
	localparam int RLW = (RW > LENGTH_W) ? RW : LENGTH_W;

	logic [CFG_DATA_W-1:0] pattern_bytes_q;
	logic [LENGTH_W-1:0]   pattern_length_q;
	logic [CFG_DATA_W-1:0] replacement_bytes_q;
	logic [LENGTH_W-1:0]   replacement_length_q;
	logic                  replace_every_q;

	logic [MAX_PATTERN-1:0][7:0] window_q;
	logic [PW-1:0]               fill_q;
	logic                        first_done_q;

	logic                        accept;
	logic [PW-1:0]               fill_ins;
	logic [PW-1:0]               fill_after;
	logic [PLW-1:0]              plen_wide;
	logic [PW-1:0]               plen;
	logic [RLW-1:0]              rlen_wide;
	logic [RW-1:0]               rlen;
	logic                        pass_mode;
	logic                        check;
	logic                        all_same;
	logic                        hit;
	logic                        emit_one;
	logic [MAX_PATTERN-1:0][7:0] win_ins;
	logic [MAX_PATTERN-1:0][7:0] win_next;
	logic [PW-1:0]               fill_next;
	logic                        first_done_next;

	assign text_stall = queue_full;

	always_comb begin
		accept = text_valid && !queue_full;

		// Clamp the insert point to the last slot.
		fill_ins   = (fill_q >= PW'(MAX_PATTERN)) ? PW'(MAX_PATTERN - 1) : fill_q;
		fill_after = fill_ins + PW'(1);

		plen_wide = PLW'(pattern_length_q);
		plen      = (plen_wide > PLW'(MAX_PATTERN)) ? PW'(MAX_PATTERN) : PW'(plen_wide);
		rlen_wide = RLW'(replacement_length_q);
		rlen      = (rlen_wide > RLW'(MAX_REPLACEMENT)) ? RW'(MAX_REPLACEMENT) :
			RW'(rlen_wide);

		pass_mode = (plen == '0) || (first_done_q && !replace_every_q);
		check     = !pass_mode && (fill_after >= plen);

		all_same = 1'b1;
		for (int k = 0; k < MAX_PATTERN; k++) begin
			win_ins[k] = (PW'(k) == fill_ins) ? text.text_byte : window_q[k];
			if ((PW'(k) < plen) && (win_ins[k] != byte_of(pattern_bytes_q, k))) begin
				all_same = 1'b0;
			end
		end
		hit      = check && all_same;
		emit_one = pass_mode || (check && !all_same);

		cmd_bytes = '0;
		if (hit) begin
			for (int k = 0; k < MAX_REPLACEMENT; k++) begin
				cmd_bytes[k] = byte_of(replacement_bytes_q, k);
			end
		end else begin
			for (int k = 0; k < MAX_PATTERN; k++) begin
				cmd_bytes[k] = win_ins[k];
			end
		end

		// A match sends the replacement; on the last byte send the whole window.
		if (hit) begin
			cmd_count = CW'(rlen);
		end else if (text.end_of_text) begin
			cmd_count = CW'(fill_after);
		end else if (emit_one) begin
			cmd_count = CW'(1);
		end else begin
			cmd_count = '0;
		end
		cmd_last = text.end_of_text;
		cmd_push = accept && (text.end_of_text || (cmd_count != '0));

		// Advance the window.
		win_next        = win_ins;
		fill_next       = fill_after;
		first_done_next = first_done_q;
		if (emit_one) begin
			for (int k = 0; k < MAX_PATTERN - 1; k++) begin
				win_next[k] = win_ins[k + 1];
			end
			fill_next = fill_after - PW'(1);
		end else if (hit) begin
			fill_next = '0;
			if (!replace_every_q) begin
				first_done_next = 1'b1;
			end
		end
		if (text.end_of_text) begin
			fill_next       = '0;
			first_done_next = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			window_q <= win_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_bytes_q      <= PATTERN_BYTES_RST;
			pattern_length_q     <= PATTERN_LENGTH_RST;
			replacement_bytes_q  <= REPLACEMENT_BYTES_RST;
			replacement_length_q <= REPLACEMENT_LENGTH_RST;
			replace_every_q      <= REPLACE_EVERY_RST;
			fill_q               <= '0;
			first_done_q         <= 1'b0;
		end else begin
			if (accept) begin
				fill_q       <= fill_next;
				first_done_q <= first_done_next;
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_PATTERN_BYTES: pattern_bytes_q <= cfg_data;
					REG_PATTERN_LENGTH: begin
						pattern_length_q <= cfg_data[LENGTH_W-1:0];
						fill_q           <= '0;
					end
					REG_REPLACEMENT_BYTES: replacement_bytes_q <= cfg_data;
					REG_REPLACEMENT_LENGTH: replacement_length_q <= cfg_data[LENGTH_W-1:0];
					REG_REPLACE_EVERY: replace_every_q <= cfg_data[0];
					default: ;
				endcase
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/srep_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Emit back
// Walks the queued command one byte per cycle while the output is not stalled,
// applies the output limit and closes each text with an end marker.
// ----------------------------------------------------------------------------
module srep_back import srep_pkg::*; #(
	parameter int MAX_PATTERN     = MAX_PATTERN_DEF,
	parameter int MAX_REPLACEMENT = MAX_REPLACEMENT_DEF,
	localparam int CMAX = (MAX_PATTERN > MAX_REPLACEMENT) ? MAX_PATTERN : MAX_REPLACEMENT,
	localparam int CW   = $clog2(CMAX + 1)
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	input  wire logic [CMAX-1:0][7:0]   head_bytes,
	input  wire logic [CW-1:0]          head_count,
	input  wire logic                   head_last,
	input  wire logic                   queue_empty,
	output logic                        queue_pop,
	output logic                        result_valid,
	input  wire logic                   result_stall,
	output out_item_t                   result
);

	localparam int IW = (CMAX > 1) ? $clog2(CMAX) : 1;

	logic [COUNT_W-1:0] output_limit_q;
	logic [COUNT_W-1:0] kept_q;
	logic [CW-1:0]      idx_q;
	logic               result_valid_q;
	out_item_t          result_q;

	logic load;
	logic step;
	logic byte_due;
	logic room;
	logic last_byte;
	logic take_byte;
	logic send_end;

	always_comb begin
		load      = !result_valid_q || !result_stall;
		step      = load && !queue_empty;
		byte_due  = idx_q < head_count;
		room      = kept_q < output_limit_q;
		last_byte = (idx_q + CW'(1)) == head_count;
		take_byte = step && byte_due && room;
		// Once the limit is hit, drop what is left of the command.
		send_end  = step && !(byte_due && room) && head_last;
		queue_pop = step && (!(byte_due && room) || (last_byte && !head_last));
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	always_ff @(posedge clk) begin
		if (take_byte) begin
			result_q.out_byte      <= head_bytes[idx_q[IW-1:0]];
			result_q.byte_present  <= 1'b1;
			result_q.end_of_result <= 1'b0;
			result_q.result_length <= '0;
		end else if (send_end) begin
			result_q.out_byte      <= 8'd0;
			result_q.byte_present  <= 1'b0;
			result_q.end_of_result <= 1'b1;
			result_q.result_length <= kept_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			output_limit_q <= OUTPUT_LIMIT_RST;
			kept_q         <= '0;
			idx_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (load) begin
				result_valid_q <= take_byte || send_end;
			end
			if (take_byte) begin
				kept_q <= kept_q + COUNT_W'(1);
				idx_q  <= (last_byte && !head_last) ? '0 : idx_q + CW'(1);
			end else if (step) begin
				idx_q <= '0;
				if (send_end) begin
					kept_q <= '0;
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_OUTPUT_LIMIT: output_limit_q <= cfg_data[COUNT_W-1:0];
					default: ;
				endcase
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/stream_pattern_replace_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Path: the command that a text byte yields is written into the command queue, and the emit
// back then registers its results. Throughput: one text byte per cycle while each byte yields
// at most one result and the queue is not full; a replacement, or the end of a text with its
// flushed bytes and end marker, keeps the emit back busy with each result; the queue absorbs those bursts.
// Reset: clears the window, counters, command queue and output valid at once; registers take
// their reset values. No clearing pass is needed.
// ----------------------------------------------------------------------------
// Stream pattern replace
// Streaming find-and-replace on a byte stream, split into a match front, a
// command queue and an emit back.
// ----------------------------------------------------------------------------
module stream_pattern_replace_top import srep_pkg::*; #(
	parameter int MAX_PATTERN     = MAX_PATTERN_DEF,
	parameter int MAX_REPLACEMENT = MAX_REPLACEMENT_DEF,
	parameter int QUEUE_DEPTH     = QUEUE_DEPTH_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                   text_valid,
	output logic                        text_stall,
	input  wire in_item_t               text,
	output logic                        result_valid,
	input  wire logic                   result_stall,
	output out_item_t                   result
);

	// Widest command: a full window or a full replacement.
	localparam int CMAX = (MAX_PATTERN > MAX_REPLACEMENT) ? MAX_PATTERN : MAX_REPLACEMENT;
	localparam int CW   = $clog2(CMAX + 1);
	localparam int QW   = 1 + CW + 8 * CMAX;

	logic                 cmd_push;
	logic [CMAX-1:0][7:0] cmd_bytes;
	logic [CW-1:0]        cmd_count;
	logic                 cmd_last;
	logic [QW-1:0]        head_data;
	logic [CMAX-1:0][7:0] head_bytes;
	logic [CW-1:0]        head_count;
	logic                 head_last;
	logic                 queue_pop;
	logic                 queue_full;
	logic                 queue_empty;

	// Front: take one text byte per transfer, match it against the pattern and
	// queue the bytes it releases. Stall only when the queue is full.
	srep_front #(
		.MAX_PATTERN     (MAX_PATTERN),
		.MAX_REPLACEMENT (MAX_REPLACEMENT)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.text_valid (text_valid),
		.text_stall (text_stall),
		.text       (text),
		.cmd_push   (cmd_push),
		.cmd_bytes  (cmd_bytes),
		.cmd_count  (cmd_count),
		.cmd_last   (cmd_last),
		.queue_full (queue_full)
	);

	// Queue: decouple front and back so a replacement burst or a stalled
	// consumer does not hold the front at once.
	srep_queue #(
		.WIDTH (QW),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (cmd_push),
		.push_data ({cmd_last, cmd_count, cmd_bytes}),
		.pop       (queue_pop),
		.head_data (head_data),
		.full      (queue_full),
		.empty     (queue_empty)
	);

	assign head_bytes = head_data[8*CMAX-1:0];
	assign head_count = head_data[8*CMAX +: CW];
	assign head_last  = head_data[QW-1];

	// Back: emit one result per cycle into the output register while the consumer does not
	// stall, drop bytes past the limit and close each text with the end marker.
	srep_back #(
		.MAX_PATTERN     (MAX_PATTERN),
		.MAX_REPLACEMENT (MAX_REPLACEMENT)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.head_bytes   (head_bytes),
		.head_count   (head_count),
		.head_last    (head_last),
		.queue_empty  (queue_empty),
		.queue_pop    (queue_pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule
`default_nettype wire

// ===== rtl/srep_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Stream pattern replace checker
// Port-level checks on result transfers, bound to the top level.
// ----------------------------------------------------------------------------
module srep_checker import srep_pkg::*; (
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   cfg_we,
	input wire logic [CFG_INDEX_W-1:0] cfg_index,
	input wire logic [CFG_DATA_W-1:0]  cfg_data,
	input wire logic                   result_valid,
	input wire logic                   result_stall,
	input wire out_item_t              result
);

	logic [COUNT_W-1:0] seen_q;
	logic [COUNT_W-1:0] limit_q;
	logic               xfer;

	assign xfer = result_valid && !result_stall;

	// Count byte transfers of the current text and track the limit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q  <= '0;
			limit_q <= OUTPUT_LIMIT_RST;
		end else begin
			if (xfer && result.end_of_result) begin
				seen_q <= '0;
			end else if (xfer && result.byte_present) begin
				seen_q <= seen_q + COUNT_W'(1);
			end
			if (cfg_we && (cfg_index == REG_OUTPUT_LIMIT)) begin
				limit_q <= cfg_data[COUNT_W-1:0];
			end
		end
	end

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	a_length_matches: assert property (@(posedge clk) disable iff (!arst_n)
		xfer && result.end_of_result |-> result.result_length == seen_q)
		else $error("end marker length differs from bytes transferred");

	a_within_limit: assert property (@(posedge clk) disable iff (!arst_n)
		xfer && result.byte_present |-> seen_q < limit_q)
		else $error("byte transferred beyond the output limit");

endmodule

bind stream_pattern_replace_top srep_checker u_srep_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.cfg_we       (cfg_we),
	.cfg_index    (cfg_index),
	.cfg_data     (cfg_data),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);
`default_nettype wire

// ===== dv/stream_pattern_replace_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stream pattern replace checker
// Follows register writes and text transfers, predicts the rewritten stream
// and compares every result transfer with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module stream_pattern_replace_checker import srep_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   text_valid,
	input  logic                   text_stall,
	input  in_item_t               text,
	input  logic                   result_valid,
	input  logic                   result_stall,
	input  out_item_t              result,
	output int unsigned            mismatch_count,
	output int unsigned            outstanding
);

	logic [CFG_DATA_W-1:0] pattern_word;
	logic [LENGTH_W-1:0]   pattern_len;
	logic [CFG_DATA_W-1:0] subst_word;
	logic [LENGTH_W-1:0]   subst_len;
	logic                  every_match;
	logic [COUNT_W-1:0]    keep_limit;

	logic [7:0]            window [MAX_PATTERN_DEF];
	int unsigned           window_fill;
	logic                  first_replaced;
	logic [COUNT_W-1:0]    kept_count;

	out_item_t             rewritten_q [$];

	task automatic clear_text();
		for (int k = 0; k < MAX_PATTERN_DEF; k++) begin
			window[k] = 8'd0;
		end
		window_fill    = 0;
		first_replaced = 1'b0;
		kept_count     = '0;
	endtask

	// Drop the byte once the limit is reached.
	task automatic keep_byte(input logic [7:0] value);
		if (kept_count < keep_limit) begin
			rewritten_q.push_back(out_item_t'{out_byte: value, byte_present: 1'b1,
				end_of_result: 1'b0, result_length: '0});
			kept_count++;
		end
	endtask

	task automatic release_oldest();
		if (window_fill != 0) begin
			keep_byte(window[0]);
			for (int k = 1; k < window_fill; k++) begin
				window[k-1] = window[k];
			end
			window_fill--;
		end
	endtask

	task automatic rewrite_byte(input in_item_t item);
		int unsigned plen;
		int unsigned rlen;
		logic        bypass;
		logic        hit;
		plen   = (pattern_len > MAX_PATTERN_DEF) ? MAX_PATTERN_DEF : pattern_len;
		rlen   = (subst_len > MAX_REPLACEMENT_DEF) ? MAX_REPLACEMENT_DEF : subst_len;
		bypass = (plen == 0) || (first_replaced && !every_match);
		if (window_fill >= MAX_PATTERN_DEF) begin
			window_fill = MAX_PATTERN_DEF - 1;
		end
		window[window_fill] = item.text_byte;
		window_fill++;
		if (bypass) begin
			release_oldest();
		end else if (window_fill >= plen) begin
			hit = 1'b1;
			for (int k = 0; k < plen; k++) begin
				if (window[k] != pattern_word[8*k +: 8]) hit = 1'b0;
			end
			if (hit) begin
				for (int k = 0; k < rlen; k++) begin
					keep_byte(subst_word[8*k +: 8]);
				end
				window_fill = 0;
				if (!every_match) first_replaced = 1'b1;
			end else begin
				release_oldest();
			end
		end
		if (item.end_of_text) begin
			while (window_fill != 0) begin
				release_oldest();
			end
			rewritten_q.push_back(out_item_t'{out_byte: 8'd0, byte_present: 1'b0,
				end_of_result: 1'b1, result_length: kept_count});
			clear_text();
		end
	endtask

	task automatic apply_write(input logic [CFG_INDEX_W-1:0] index,
			input logic [CFG_DATA_W-1:0] data);
		case (index)
			REG_PATTERN_BYTES: begin
				pattern_word = data;
			end
			REG_PATTERN_LENGTH: begin
				pattern_len = data[LENGTH_W-1:0];
				window_fill = 0;
			end
			REG_REPLACEMENT_BYTES: begin
				subst_word = data;
			end
			REG_REPLACEMENT_LENGTH: begin
				subst_len = data[LENGTH_W-1:0];
			end
			REG_REPLACE_EVERY: begin
				every_match = data[0];
			end
			REG_OUTPUT_LIMIT: begin
				keep_limit = data[COUNT_W-1:0];
			end
			default: begin
			end
		endcase
	endtask

	task automatic check_result(input out_item_t got);
		out_item_t want;
		if (rewritten_q.size() == 0) begin
			$error("result with nothing expected: out_byte %0h byte_present %0b end_of_result %0b result_length %0d",
				got.out_byte, got.byte_present, got.end_of_result, got.result_length);
			mismatch_count++;
		end else begin
			want = rewritten_q.pop_front();
			if (got.out_byte !== want.out_byte) begin
				$error("out_byte: expected %0h, got %0h", want.out_byte, got.out_byte);
				mismatch_count++;
			end
			if (got.byte_present !== want.byte_present) begin
				$error("byte_present: expected %0b, got %0b", want.byte_present, got.byte_present);
				mismatch_count++;
			end
			if (got.end_of_result !== want.end_of_result) begin
				$error("end_of_result: expected %0b, got %0b", want.end_of_result,
					got.end_of_result);
				mismatch_count++;
			end
			if (got.result_length !== want.result_length) begin
				$error("result_length: expected %0d, got %0d", want.result_length,
					got.result_length);
				mismatch_count++;
			end
		end
	endtask

	// Results first, so a spurious result never consumes a prediction of this edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_word   = PATTERN_BYTES_RST;
			pattern_len    = PATTERN_LENGTH_RST;
			subst_word     = REPLACEMENT_BYTES_RST;
			subst_len      = REPLACEMENT_LENGTH_RST;
			every_match    = REPLACE_EVERY_RST;
			keep_limit     = OUTPUT_LIMIT_RST;
			clear_text();
			rewritten_q.delete();
			mismatch_count = 0;
		end else begin
			if (result_valid && !result_stall) check_result(result);
			if (cfg_we) apply_write(cfg_index, cfg_data);
			if (text_valid && !text_stall) rewrite_byte(text);
		end
		outstanding <= rewritten_q.size();
	end

endmodule

// ===== dv/stream_pattern_replace_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stream pattern replace testbench
// Drives directed and random texts through the find-and-replace block under
// changing register settings and back-pressure; a separate checker predicts
// every result transfer and counts mismatches for the final verdict.
// ----------------------------------------------------------------------------
module stream_pattern_replace_top_tb;
	import srep_pkg::*;

	localparam int unsigned QUIET_CYCLES     = 12;
	localparam int unsigned BACKLOG_CYCLES   = 80;
	localparam int unsigned WATCHDOG_LIMIT   = 3000;
	localparam int unsigned ITEMS_PER_REGIME = 35;

	logic                   clk          = 1'b0;
	logic                   arst_n       = 1'b0;
	logic                   cfg_we       = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index    = '0;
	logic [CFG_DATA_W-1:0]  cfg_data     = '0;
	logic                   text_valid   = 1'b0;
	logic                   text_stall;
	in_item_t               text         = '0;
	logic                   result_valid;
	logic                   result_stall = 1'b0;
	out_item_t              result;

	int unsigned            mismatch_count;
	int unsigned            outstanding;

	// Idling odds in percent, changed by the stimulus between regimes.
	int unsigned            send_idle_pct = 30;
	int unsigned            recv_idle_pct = 65;
	logic                   backlog_req   = 1'b0;
	int unsigned            items_sent    = 0;
	int unsigned            quiet_count   = 0;

	// Shadow of the pattern, so random texts can be built around it.
	logic [CFG_DATA_W-1:0]  cur_pattern     = PATTERN_BYTES_RST;
	logic [LENGTH_W-1:0]    cur_pattern_len = PATTERN_LENGTH_RST;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	stream_pattern_replace_top DUT (
		.clk,
		.arst_n,
		.cfg_we,
		.cfg_index,
		.cfg_data,
		.text_valid,
		.text_stall,
		.text,
		.result_valid,
		.result_stall,
		.result
	);

	stream_pattern_replace_checker rewrite_check (
		.clk,
		.arst_n,
		.cfg_we,
		.cfg_index,
		.cfg_data,
		.text_valid,
		.text_stall,
		.text,
		.result_valid,
		.result_stall,
		.result,
		.mismatch_count,
		.outstanding
	);

	// Receiver: random stall, and one long hold-off each time a backlog is requested.
	// The hold-off is counted here, while the sender keeps offering text.
	initial begin
		logic backlog_done;
		backlog_done = 1'b0;
		forever begin
			@(posedge clk);
			if (backlog_req && !backlog_done) begin
				backlog_done = 1'b1;
				result_stall <= 1'b1;
				repeat (BACKLOG_CYCLES) @(posedge clk);
			end
			if (!backlog_req) backlog_done = 1'b0;
			result_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// Watchdog: any transfer or register write counts as progress.
	always @(posedge clk) begin
		if ((text_valid && !text_stall) || (result_valid && !result_stall) || cfg_we) begin
			quiet_count <= 0;
		end else if (quiet_count >= WATCHDOG_LIMIT) begin
			$error("no transfer for %0d cycles", WATCHDOG_LIMIT);
			$display("stream_pattern_replace_top verification failed");
			$finish;
		end else begin
			quiet_count <= quiet_count + 1;
		end
	end

	// Offer one text byte and hold it until the transfer. Valid is only lowered for a
	// gap, so back-to-back bytes keep it high without a second assignment in a step.
	task automatic send_item(input logic [7:0] value, input logic last);
		if ($urandom_range(99) < send_idle_pct) begin
			text_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		text_valid <= 1'b1;
		text       <= in_item_t'{text_byte: value, end_of_text: last};
		do @(posedge clk); while (text_stall);
		items_sent++;
	endtask

	// Send the first count bytes of a word, lowest byte first.
	task automatic send_bytes(input logic [CFG_DATA_W-1:0] word, input int unsigned count,
			input logic terminate);
		for (int k = 0; k < count; k++) begin
			send_item(word[8*k +: 8], terminate && (k == count - 1));
		end
	endtask

	// Leave cfg_we high; the caller drops it after the last write of a group.
	task automatic write_reg(input cfg_reg_t index, input logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_data  <= data;
		@(posedge clk);
		if (index == REG_PATTERN_BYTES) cur_pattern = data;
		if (index == REG_PATTERN_LENGTH) cur_pattern_len = data[LENGTH_W-1:0];
	endtask

	// Drain: wait for every predicted result, then stay idle so the block
	// clears before registers are touched.
	task automatic settle();
		text_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	// Build a text around the current pattern: whole matches, broken-off prefixes,
	// stray pattern bytes and plain noise across the full byte range.
	task automatic send_text(input int unsigned len, input logic terminate);
		int unsigned plen;
		int unsigned done;
		int unsigned run;
		int unsigned pick;
		int unsigned idx;
		logic [7:0]  value;
		plen = (cur_pattern_len > MAX_PATTERN_DEF) ? MAX_PATTERN_DEF : cur_pattern_len;
		done = 0;
		while (done < len) begin
			pick = $urandom_range(99);
			if (plen != 0 && pick < 40) begin
				run = (pick < 30) ? plen : $urandom_range(plen, 1);
				for (int k = 0; k < run && done < len; k++) begin
					send_item(cur_pattern[8*k +: 8], terminate && (done == len - 1));
					done++;
				end
			end else begin
				idx   = (plen != 0) ? $urandom_range(plen - 1) : 0;
				value = (plen != 0 && pick < 70) ? cur_pattern[8*idx +: 8] : 8'($urandom);
				send_item(value, terminate && (done == len - 1));
				done++;
			end
		end
	endtask

	// Pick a register setting, leaning on the extremes: empty and saturating
	// lengths, zero and all-ones words, a zero or tiny output limit.
	task automatic random_setup(input logic write_all);
		int unsigned           pick;
		logic [CFG_DATA_W-1:0] word;
		if (write_all || $urandom_range(1)) begin
			pick = $urandom_range(9);
			word = {$urandom, $urandom};
			if (pick == 0) word = '0;
			else if (pick == 1) word = '1;
			write_reg(REG_PATTERN_BYTES, word);
		end
		if (write_all || $urandom_range(1)) begin
			pick = $urandom_range(9);
			case (pick)
				0: word = 0;
				1: word = 15;
				2: word = MAX_PATTERN_DEF;
				3: word = $urandom_range(15, 5);
				default: word = $urandom_range(4, 1);
			endcase
			write_reg(REG_PATTERN_LENGTH, word);
		end
		if (write_all || $urandom_range(1)) begin
			pick = $urandom_range(9);
			word = {$urandom, $urandom};
			if (pick == 0) word = '0;
			else if (pick == 1) word = '1;
			write_reg(REG_REPLACEMENT_BYTES, word);
		end
		if (write_all || $urandom_range(1)) begin
			pick = $urandom_range(9);
			case (pick)
				0: word = 0;
				1: word = 15;
				2: word = MAX_REPLACEMENT_DEF;
				default: word = $urandom_range(4);
			endcase
			write_reg(REG_REPLACEMENT_LENGTH, word);
		end
		if (write_all || $urandom_range(1)) begin
			write_reg(REG_REPLACE_EVERY, $urandom_range(1));
		end
		if (write_all || $urandom_range(1)) begin
			pick = $urandom_range(9);
			case (pick)
				0: word = 0;
				1, 2: word = $urandom_range(16, 1);
				3: word = $urandom_range(65534, 17);
				default: word = 16'hFFFF;
			endcase
			write_reg(REG_OUTPUT_LIMIT, word);
		end
		cfg_we <= 1'b0;
	endtask

	// One idling regime: a backlog burst first, then phases of new settings and texts.
	// A phase may stop mid-text, so the next writes land on a half-seen text.
	task automatic random_regime(input int unsigned send_pct, input int unsigned recv_pct);
		int unsigned stop_at;
		int unsigned texts;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		stop_at       = items_sent + ITEMS_PER_REGIME;
		settle();
		random_setup(1'b1);
		backlog_req <= 1'b1;
		send_text(16, 1'b1);
		while (items_sent < stop_at) begin
			settle();
			random_setup(1'b0);
			texts = $urandom_range(3, 1);
			for (int t = 0; t < texts; t++) begin
				send_text($urandom_range(14, 1), (t < texts - 1) || ($urandom_range(3) != 0));
			end
		end
		backlog_req <= 1'b0;
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Reset setting: the pattern is one zero byte and matches are deleted.
		settle();
		send_bytes(64'h00_FF_00, 3, 1'b1);

		// Two-byte pattern with a partial match ahead of the real one, replaced by three.
		settle();
		write_reg(REG_PATTERN_BYTES, 64'h6261);
		write_reg(REG_PATTERN_LENGTH, 2);
		write_reg(REG_REPLACEMENT_BYTES, 64'h5A5958);
		write_reg(REG_REPLACEMENT_LENGTH, 3);
		cfg_we <= 1'b0;
		send_bytes(64'h63_62_61_62_61_61, 6, 1'b1);

		// First match only, with a limit that cuts the replacement short.
		settle();
		write_reg(REG_REPLACE_EVERY, 0);
		write_reg(REG_REPLACEMENT_BYTES, 64'hFFEE_DDCC_BBAA_9988);
		write_reg(REG_REPLACEMENT_LENGTH, MAX_REPLACEMENT_DEF);
		write_reg(REG_OUTPUT_LIMIT, 5);
		cfg_we <= 1'b0;
		send_bytes(64'h78_62_61_62_61, 5, 1'b1);

		// No pattern: straight pass, but a zero limit keeps nothing.
		settle();
		write_reg(REG_PATTERN_LENGTH, 0);
		write_reg(REG_OUTPUT_LIMIT, 0);
		cfg_we <= 1'b0;
		send_bytes(64'hA5_5A, 2, 1'b1);

		// Oversized lengths saturate: an all-ones pattern of eight bytes.
		settle();
		write_reg(REG_PATTERN_BYTES, '1);
		write_reg(REG_PATTERN_LENGTH, 15);
		write_reg(REG_REPLACEMENT_BYTES, 64'h0123_4567_89AB_CDEF);
		write_reg(REG_REPLACEMENT_LENGTH, 15);
		write_reg(REG_REPLACE_EVERY, 1);
		write_reg(REG_OUTPUT_LIMIT, 16'hFFFF);
		cfg_we <= 1'b0;
		send_bytes('1, 8, 1'b0);
		send_bytes(64'h7F, 1, 1'b1);

		random_regime(30, 65);
		random_regime(65, 30);
		random_regime(0, 0);

		settle();
		if (mismatch_count == 0) begin
			$display("stream_pattern_replace_top verification clean");
		end else begin
			$display("stream_pattern_replace_top verification failed");
		end
		$finish;
	end

endmodule
